[design/mlt_pkg.sv]
// Shared constants, state encoding and compare result type for the MAC learning table.
package mlt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int MAC_W   = 48;
   localparam int PORT_W  = 4;
   localparam int SLOT_W  = 4;
   localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int ENTRY_W = MAC_W + PORT_W;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_BITS = 2 * MAC_W + PORT_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + SLOT_W + 1 + PORT_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_LEARN = 3'b100
   } state_type;

   // Outcome of comparing one table entry against both addresses
   typedef struct packed {
      logic src_eq;
      logic dst_eq;
   } cmp_res_type;

endpackage

[design/mlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mlt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/mlt_cmp.sv]
// Shared address compare unit: matches one stored entry against source and destination.
module mlt_cmp
   import mlt_pkg::*;
(
   input  logic [MAC_W-1:0] entry_mac,
   input  logic [MAC_W-1:0] src_mac,
   input  logic [MAC_W-1:0] dst_mac,
   output cmp_res_type      res
);

   // Compare the entry against both addresses of the frame
   always_comb begin
      res.src_eq = (entry_mac == src_mac);
      res.dst_eq = (entry_mac == dst_mac);
   end

endmodule

[design/mac_learning_table_top.sv]
// Top level of the MAC learning table: frame handshake, scan sequencer and learn/lookup logic.
//
// Each accepted frame is handled alone: the sequencer reads the filled table
// entries one per cycle through the single read port of the table RAM and
// checks each against the source and destination in one compare unit. A frame
// is accepted in the idle state, then scanned, with each entry compared once
// its registered read data arrives, and then reaches the learn state, which
// waits until the output register is free and then registers the result. The
// block takes a new frame as soon as the learn state has placed its result in
// the output register, even while that result still waits to be taken. The
// table needs no clearing after reset; only filled entries are ever read.
module mac_learning_table_top
   import mlt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // req_tdata: src_mac[47:0], dst_mac[95:48], ingress_port[99:96], zero pad
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // rsp_tdata: learn_ok[0], learn_slot[4:1], dest_found[5], egress_port[9:6], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   // Control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Frame and scan payload
   logic [MAC_W-1:0]  src_ff, src_in;
   logic [MAC_W-1:0]  dst_ff, dst_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              src_hit_ff, src_hit_in;
   logic [IDX_W-1:0]  src_idx_ff, src_idx_in;
   logic              dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Table and compare unit wiring
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   cmp_res_type        cmp_res;

   // Learn-cycle decisions
   logic             accept;
   logic             out_free;
   logic             full;
   logic             learn_ok;
   logic [IDX_W-1:0] learn_idx;
   logic [EXT_W-1:0] learn_ext;
   logic             dest_found;
   logic [PORT_W-1:0] egress_port;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CNT_W'(TABLE_DEPTH));

   // Table memory: MAC address in the upper bits, port in the lower bits
   mlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({src_ff, port_ff}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Single compare unit shared by every entry of the scan
   mlt_cmp u_cmp (
      .entry_mac (rd_data[ENTRY_W-1:PORT_W]),
      .src_mac   (src_ff),
      .dst_mac   (dst_ff),
      .res       (cmp_res)
   );

   // Learn decisions: update an existing entry, append, or drop when full
   always_comb begin
      learn_ok  = src_hit_ff || !full;
      learn_idx = src_hit_ff ? src_idx_ff : count_ff[IDX_W-1:0];
      learn_ext = learn_ok ? EXT_W'(learn_idx) : '0;
      // Destination equal to source sees this frame's port once it is learned
      if (learn_ok && (dst_ff == src_ff)) begin
         dest_found  = 1'b1;
         egress_port = port_ff;
      end else if (dst_hit_ff) begin
         dest_found  = 1'b1;
         egress_port = dst_port_ff;
      end else begin
         dest_found  = 1'b0;
         egress_port = '0;
      end
   end

   assign wr_en   = (state_ff == ST_LEARN) && out_free && learn_ok;
   assign wr_addr = learn_idx;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      src_in       = src_ff;
      dst_in       = dst_ff;
      port_in      = port_ff;
      cmp_idx_in   = cmp_idx_ff;
      src_hit_in   = src_hit_ff;
      src_idx_in   = src_idx_ff;
      dst_hit_in   = dst_hit_ff;
      dst_port_in  = dst_port_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Capture the frame and start the scan at entry zero
            if (accept) begin
               src_in     = req_tdata[MAC_W-1:0];
               dst_in     = req_tdata[2*MAC_W-1:MAC_W];
               port_in    = req_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
               issue_in   = '0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue the next filled entry
            if (issue_ff < count_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               state_in = ST_LEARN;
            end
            // Record the first match of each address
            if (cmp_vld_ff) begin
               if (cmp_res.src_eq && !src_hit_ff) begin
                  src_hit_in = 1'b1;
                  src_idx_in = cmp_idx_ff;
               end
               if (cmp_res.dst_eq && !dst_hit_ff) begin
                  dst_hit_in  = 1'b1;
                  dst_port_in = rd_data[PORT_W-1:0];
               end
            end
         end
         ST_LEARN: begin
            // Commit the learn and load the result once the output is free
            if (out_free) begin
               if (!src_hit_ff && !full) begin
                  count_in = count_ff + CNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {egress_port, dest_found, learn_ext[SLOT_W-1:0], learn_ok};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      port_ff     <= port_in;
      cmp_idx_ff  <= cmp_idx_in;
      src_hit_ff  <= src_hit_in;
      src_idx_ff  <= src_idx_in;
      dst_hit_ff  <= dst_hit_in;
      dst_port_ff <= dst_port_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule
